// ===== hw/rtl/mhpq_pkg.sv =====
// Shared constants, types and command codes of the min-heap priority queue.
package mhpq_pkg;

   localparam int CAPACITY = 1024;
   localparam int DATA_W   = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_PEEK   = 2'd2;

   typedef logic signed [DATA_W-1:0] data_type;

   localparam data_type EMPTY_MIN = data_type'(-1);

   typedef struct packed {
      logic              ins;
      data_type          value;
      logic [CNT_W-1:0]  count;
   } bcast_type;

endpackage

// ===== hw/rtl/mhpq_if.sv =====
// Request and response channel interfaces of the min-heap priority queue.
interface mhpq_req_if import mhpq_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [1:0]           cmd;
   data_type             value;

   modport source (output valid, cmd, value, input ready);
   modport sink   (input valid, cmd, value, output ready);
endinterface

interface mhpq_rsp_if import mhpq_pkg::*; ;
   logic                 valid;
   logic                 ready;
   data_type             min_value;
   logic                 is_empty;
   logic                 found;
   logic                 overflow;

   modport source (output valid, min_value, is_empty, found, overflow, input ready);
   modport sink   (input valid, min_value, is_empty, found, overflow, output ready);
endinterface

// ===== hw/rtl/min_heap_priority_queue_top.sv =====
// Top level of the min-heap priority queue: sequencer and sorted chain of cells.
// Usage:
//   req_bus carries one request: cmd (insert, delete one copy, peek; code 3 acts
//   as peek) and a signed 32-bit value. rsp_bus returns one response per
//   request: the minimum stored value (-1 when empty), is_empty, found
//   (delete removed a copy) and overflow (insert dropped, store full).
//   Both channels are valid/ready; a transfer happens when both are high.
//   Values live in a chain of CAPACITY cells kept in ascending order, so the
//   minimum always sits in the first cell.
//   Insert and peek pass from acceptance through the EXEC and DONE states to
//   the response register. A delete sends a match token down the chain, one
//   cell per cycle, and responds after the token reaches the last cell.
//   One request is in work at a time; the next is accepted once the
//   previous one has reached the response register, while it still waits.
//   A stalled receiver holds the response; the block stops before loading
//   the following response until the register frees up.
//   Reset empties the store at once; no clearing pass is needed.
module min_heap_priority_queue_top import mhpq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mhpq_req_if.sink    req_bus,
   mhpq_rsp_if.source  rsp_bus
);

   bcast_type  bc;
   logic       scan_start;
   data_type   cell_value [CAPACITY];
   logic       cell_gt    [CAPACITY];
   logic       cell_token [CAPACITY];
   logic       cell_hit   [CAPACITY];

   mhpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .head_value (cell_value[0]),
      .tail_token (cell_token[CAPACITY-1]),
      .tail_hit   (cell_hit[CAPACITY-1]),
      .bc         (bc),
      .scan_start (scan_start)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      data_type left_value;
      logic     left_gt;
      data_type right_value;
      logic     token_in;
      logic     hit_in;

      if (i == 0) begin : g_first
         assign left_value = '0;
         assign left_gt    = 1'b0;
         assign token_in   = scan_start;
         assign hit_in     = 1'b0;
      end else begin : g_inner
         assign left_value = cell_value[i-1];
         assign left_gt    = cell_gt[i-1];
         assign token_in   = cell_token[i-1];
         assign hit_in     = cell_hit[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_body
         assign right_value = cell_value[i+1];
      end

      mhpq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .idx         (IDX_W'(i)),
         .bc          (bc),
         .left_value  (left_value),
         .left_gt     (left_gt),
         .right_value (right_value),
         .token_in    (token_in),
         .hit_in      (hit_in),
         .value       (cell_value[i]),
         .gt          (cell_gt[i]),
         .token_out   (cell_token[i]),
         .hit_out     (cell_hit[i])
      );
   end

endmodule

// ===== hw/rtl/mhpq_cell.sv =====
// One slot of the sorted chain: holds a value, shifts on insert and on delete scan.
module mhpq_cell import mhpq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [IDX_W-1:0]  idx,
   input  bcast_type         bc,
   input  data_type          left_value,
   input  logic              left_gt,
   input  data_type          right_value,
   input  logic              token_in,
   input  logic              hit_in,
   output data_type          value,
   output logic              gt,
   output logic              token_out,
   output logic              hit_out
);

   data_type value_ff, value_in;
   logic     token_ff;
   logic     hit_ff;
   logic     occupied;
   logic     match;
   logic     hit_now;

   assign occupied  = CNT_W'(idx) < bc.count;
   assign gt        = !occupied || (bc.value < value_ff);
   assign match     = occupied && (value_ff == bc.value);
   assign hit_now   = hit_ff || match;
   assign value     = value_ff;
   assign token_out = token_ff;
   assign hit_out   = hit_now;

   always_comb begin
      value_in = value_ff;
      if (bc.ins) begin
         if (left_gt) begin
            value_in = left_value;
         end else if (gt) begin
            value_in = bc.value;
         end
      end else if (token_ff && hit_now) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= 1'b0;
      end else begin
         token_ff <= token_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      hit_ff   <= hit_in;
   end

endmodule

// ===== hw/rtl/mhpq_ctrl.sv =====
// Sequencer: takes requests, drives the cell chain, keeps the count, forms responses.
module mhpq_ctrl import mhpq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mhpq_req_if.sink    req_bus,
   mhpq_rsp_if.source  rsp_bus,
   input  data_type    head_value,
   input  logic        tail_token,
   input  logic        tail_hit,
   output bcast_type   bc,
   output logic        scan_start
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [1:0]        cmd_ff, cmd_in;
   data_type          x_ff, x_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              found_ff, found_in;
   logic              ovf_ff, ovf_in;
   logic              rsp_valid_ff, rsp_valid_in;
   data_type          rsp_min_ff, rsp_min_in;
   logic              rsp_empty_ff, rsp_empty_in;
   logic              rsp_found_ff, rsp_found_in;
   logic              rsp_ovf_ff, rsp_ovf_in;
   logic              ins;

   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.min_value = rsp_min_ff;
   assign rsp_bus.is_empty  = rsp_empty_ff;
   assign rsp_bus.found     = rsp_found_ff;
   assign rsp_bus.overflow  = rsp_ovf_ff;

   assign bc.ins   = ins;
   assign bc.value = x_ff;
   assign bc.count = count_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      x_in         = x_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_min_in   = rsp_min_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_found_in = rsp_found_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      ins          = 1'b0;
      scan_start   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               cmd_in   = req_bus.cmd;
               x_in     = req_bus.value;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            found_in = 1'b0;
            ovf_in   = 1'b0;
            state_in = ST_DONE;
            case (cmd_ff)
               CMD_INSERT: begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     ovf_in = 1'b1;
                  end else begin
                     ins      = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               CMD_DELETE: begin
                  scan_start = 1'b1;
                  state_in   = ST_SCAN;
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            if (tail_token) begin
               if (tail_hit) begin
                  found_in = 1'b1;
                  count_in = count_ff - CNT_W'(1);
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_empty_in = (count_ff == '0);
               rsp_min_in   = (count_ff == '0) ? EMPTY_MIN : head_value;
               rsp_found_in = found_ff;
               rsp_ovf_in   = ovf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      x_ff         <= x_in;
      found_ff     <= found_in;
      ovf_ff       <= ovf_in;
      rsp_min_ff   <= rsp_min_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_found_ff <= rsp_found_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

endmodule

// ===== tb/sv/tb_min_heap_priority_queue_top.sv =====
// Self-checking testbench of the min-heap priority queue: heap predictor, stimulus and checks.
module tb_min_heap_priority_queue_top import mhpq_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_SPARE    = 2'd3;
   localparam data_type   VALUE_MAX    = {1'b0, {(DATA_W - 1){1'b1}}};
   localparam data_type   VALUE_MIN    = {1'b1, {(DATA_W - 1){1'b0}}};
   localparam int         CYCLE_LIMIT  = 6_000_000;
   localparam int         SETTLE       = CAPACITY + 3 + 16;
   localparam int         REPORT_CAP   = 50;
   localparam int         RANDOM_COUNT = 300;
   localparam int         FILL_COUNT   = 100;

   typedef struct packed {
      data_type min_value;
      logic     is_empty;
      logic     found;
      logic     overflow;
   } heap_answer_type;

   logic clock;
   logic reset;

   mhpq_req_if req_bus ();
   mhpq_rsp_if rsp_bus ();

   min_heap_priority_queue_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   data_type        heap_mem [CAPACITY];
   int unsigned     heap_len = 0;
   heap_answer_type pending_answers [$];
   int              error_count = 0;
   int              cycle_count = 0;
   bit              idle_gaps   = 1'b1;
   int              long_hold   = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic void heap_swap(int unsigned a, int unsigned b);
      data_type t;
      t           = heap_mem[a];
      heap_mem[a] = heap_mem[b];
      heap_mem[b] = t;
   endfunction

   function automatic void heap_raise(int unsigned pos);
      int unsigned up;
      while (pos > 0 && pos < heap_len) begin
         up = (pos - 1) / 2;
         if (!(heap_mem[up] > heap_mem[pos]))
            break;
         heap_swap(up, pos);
         pos = up;
      end
   endfunction

   function automatic void heap_lower(int unsigned pos);
      int unsigned best, l, r;
      while (pos < heap_len) begin
         best = pos;
         l    = 2 * pos + 1;
         r    = 2 * pos + 2;
         if (l < heap_len && heap_mem[best] > heap_mem[l])
            best = l;
         if (r < heap_len && heap_mem[best] > heap_mem[r])
            best = r;
         if (best == pos)
            break;
         heap_swap(pos, best);
         pos = best;
      end
   endfunction

   function automatic heap_answer_type predict_answer(logic [1:0] cmd, data_type value);
      heap_answer_type ans;
      int unsigned     slot;
      ans = '0;
      if (cmd == CMD_INSERT) begin
         if (heap_len >= CAPACITY) begin
            ans.overflow = 1'b1;
         end else begin
            heap_mem[heap_len] = value;
            heap_len++;
            heap_raise(heap_len - 1);
         end
      end else if (cmd == CMD_DELETE) begin
         slot = 0;
         while (slot < heap_len && heap_mem[slot] != value)
            slot++;
         if (slot < heap_len) begin
            ans.found      = 1'b1;
            heap_mem[slot] = heap_mem[heap_len - 1];
            heap_len--;
            if (slot < heap_len) begin
               heap_raise(slot);
               heap_lower(slot);
            end
         end
      end
      ans.is_empty  = (heap_len == 0);
      ans.min_value = ans.is_empty ? EMPTY_MIN : heap_mem[0];
      return ans;
   endfunction

   function automatic data_type random_value();
      case ($urandom_range(0, 4))
         0, 1: return $signed($urandom_range(0, 16)) - 8;
         2: return $urandom_range(0, 1) ? VALUE_MAX - $urandom_range(0, 3)
                                         : VALUE_MIN + $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(input string field, input data_type want,
                                  input data_type got);
      error_count++;
      if (error_count <= REPORT_CAP)
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endtask

   // response checker
   always @(posedge clock) begin : check_answers
      heap_answer_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_answers.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_CAP)
               $display("%0t ns: response mismatch, expected none, actual min %0d",
                        $time, rsp_bus.min_value);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_bus.min_value !== want.min_value)
               report_mismatch("min_value", want.min_value, rsp_bus.min_value);
            if (rsp_bus.is_empty !== want.is_empty)
               report_mismatch("is_empty", data_type'(want.is_empty),
                               data_type'(rsp_bus.is_empty));
            if (rsp_bus.found !== want.found)
               report_mismatch("found", data_type'(want.found), data_type'(rsp_bus.found));
            if (rsp_bus.overflow !== want.overflow)
               report_mismatch("overflow", data_type'(want.overflow),
                               data_type'(rsp_bus.overflow));
         end
      end
   end

   // response ready: random stall bursts and requested long holds
   initial begin : drive_ready
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold > 0) begin
            stall_left = long_hold;
            long_hold  = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_gaps && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 18);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_request(input logic [1:0] cmd, input data_type value);
      if (idle_gaps && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd   <= cmd;
      req_bus.value <= value;
      do @(posedge clock); while (!req_bus.ready);
      pending_answers.push_back(predict_answer(cmd, value));
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   task automatic test_empty_store();
      send_request(CMD_PEEK, 0);
      send_request(CMD_SPARE, VALUE_MIN);
      send_request(CMD_DELETE, 0);
      send_request(CMD_DELETE, EMPTY_MIN);
   endtask

   task automatic test_extremes_and_peek();
      send_request(CMD_INSERT, VALUE_MAX);
      send_request(CMD_INSERT, VALUE_MIN);
      send_request(CMD_INSERT, 0);
      send_request(CMD_INSERT, EMPTY_MIN);
      send_request(CMD_INSERT, 0);
      send_request(CMD_PEEK, VALUE_MAX);
      send_request(CMD_SPARE, $urandom);
   endtask

   task automatic test_delete_cases();
      send_request(CMD_DELETE, 12345);
      send_request(CMD_DELETE, VALUE_MIN);
      // max now sits in the last slot
      send_request(CMD_DELETE, VALUE_MAX);
      send_request(CMD_DELETE, 0);
      send_request(CMD_DELETE, EMPTY_MIN);
      send_request(CMD_DELETE, 0);
      send_request(CMD_DELETE, 0);
      send_request(CMD_PEEK, 0);
   endtask

   task automatic run_random_mix(input int count);
      int         pick;
      logic [1:0] cmd;
      data_type   value;
      repeat (count) begin
         pick  = $urandom_range(0, 99);
         cmd   = pick < 45 ? CMD_INSERT : pick < 80 ? CMD_DELETE :
                 pick < 95 ? CMD_PEEK : CMD_SPARE;
         value = random_value();
         if (cmd == CMD_DELETE && heap_len > 0 && $urandom_range(0, 9) < 8)
            value = heap_mem[$urandom_range(0, heap_len - 1)];
         send_request(cmd, value);
      end
   endtask

   task automatic test_random_mix();
      run_random_mix(RANDOM_COUNT);
   endtask

   task automatic test_backpressure();
      long_hold = 300;
      repeat (12)
         send_request($urandom_range(0, 1) ? CMD_INSERT : CMD_PEEK, random_value());
      wait_drained();
      repeat (6)
         send_request(CMD_INSERT, random_value());
   endtask

   task automatic test_bulk_fill();
      repeat (FILL_COUNT)
         send_request(CMD_INSERT, random_value());
      send_request(CMD_PEEK, 0);
      send_request(CMD_DELETE, heap_mem[heap_len - 1]);
      send_request(CMD_DELETE, heap_mem[0]);
      repeat (3)
         send_request(CMD_INSERT, random_value());
   endtask

   task automatic test_closing_run();
      idle_gaps = 1'b0;
      run_random_mix(120);
   endtask

   initial begin : run_tests
      reset = 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.cmd   <= CMD_PEEK;
      req_bus.value <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_store();
      test_extremes_and_peek();
      test_delete_cases();
      test_random_mix();
      test_backpressure();
      test_bulk_fill();
      test_closing_run();

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
